/* hw/rtl/smc_pkg.sv */
// Package with opcode, cause and command constants and the sequencer state type.
package smc_pkg;

   localparam logic [4:0] OP_HLT   = 5'd0;
   localparam logic [4:0] OP_PSH   = 5'd1;
   localparam logic [4:0] OP_POP   = 5'd2;
   localparam logic [4:0] OP_DUP   = 5'd3;
   localparam logic [4:0] OP_SWAP  = 5'd4;
   localparam logic [4:0] OP_OVER  = 5'd5;
   localparam logic [4:0] OP_PSHSP = 5'd6;
   localparam logic [4:0] OP_POPSP = 5'd7;
   localparam logic [4:0] OP_PSHFP = 5'd8;
   localparam logic [4:0] OP_POPFP = 5'd9;
   localparam logic [4:0] OP_AND   = 5'd10;
   localparam logic [4:0] OP_OR    = 5'd11;
   localparam logic [4:0] OP_XOR   = 5'd12;
   localparam logic [4:0] OP_ADD   = 5'd13;
   localparam logic [4:0] OP_SUB   = 5'd14;
   localparam logic [4:0] OP_SHL   = 5'd15;
   localparam logic [4:0] OP_SHR   = 5'd16;
   localparam logic [4:0] OP_ASR   = 5'd17;
   localparam logic [4:0] OP_BEQ   = 5'd18;
   localparam logic [4:0] OP_BNE   = 5'd19;
   localparam logic [4:0] OP_BLT   = 5'd20;
   localparam logic [4:0] OP_BGE   = 5'd21;
   localparam logic [4:0] OP_BRA   = 5'd22;
   localparam logic [4:0] OP_JMP   = 5'd23;
   localparam logic [4:0] OP_LDW   = 5'd24;
   localparam logic [4:0] OP_STW   = 5'd25;
   localparam logic [4:0] OP_LDB   = 5'd26;
   localparam logic [4:0] OP_STB   = 5'd27;
   localparam logic [4:0] OP_IN    = 5'd28;
   localparam logic [4:0] OP_INB   = 5'd29;
   localparam logic [4:0] OP_OUT   = 5'd30;
   localparam logic [4:0] OP_OUTB  = 5'd31;

   localparam logic [1:0] CAUSE_RUN = 2'd0;
   localparam logic [1:0] CAUSE_HLT = 2'd1;
   localparam logic [1:0] CAUSE_BAD = 2'd2;

   localparam logic       CMD_WRITE = 1'b0;
   localparam logic       CMD_STEP  = 1'b1;

   localparam logic [31:0] BYTE_MASK = 32'h0000_00ff;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_DECODE,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_EXEC,
      ST_DONE
   } state_type;

endpackage

/* hw/rtl/stack_machine_core.sv */
// Top level of the stack machine core: sequencer around one shared word memory.
// A memory write or a step while halted ends after FETCH, a halting step after DECODE,
// most steps after RD1, OVER after RD2, LDW and LDB after EXEC, and SWAP, binary
// operations, branches, STW and STB after RD3. The single memory port sets these paths;
// busy stays high through the strobe cycle, so the next transaction is accepted in the
// cycle after it. Reset clears every memory word before the core goes idle.
module stack_machine_core
   import smc_pkg::*;
#(
   parameter int MEM_WORDS = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [11:0]        req_address,
   input  logic signed [31:0] req_write_data,
   input  logic signed [31:0] req_in_value,
   output logic               rsp_strobe,
   output logic               rsp_halted,
   output logic [1:0]         rsp_halt_cause,
   output logic               rsp_in_taken,
   output logic               rsp_out_valid,
   output logic               rsp_out_is_byte,
   output logic signed [31:0] rsp_out_value,
   output logic [11:0]        rsp_pc_now,
   output logic [12:0]        rsp_sp_now,
   output logic [11:0]        rsp_fp_now
);

   // MEM_WORDS must be a power of two, unchecked by the core; addresses wrap by dropping upper bits.
   localparam int AW = $clog2(MEM_WORDS);
   localparam int SW = AW + 1;
   localparam logic [SW-1:0] SP_RESET = SW'(MEM_WORDS);

   // The shared memory: one port, read data registered in the cycle after the address.
   logic [31:0]   mem_array [MEM_WORDS];
   logic [31:0]   rdata_ff;
   logic [AW-1:0] mem_addr;
   logic [31:0]   mem_wdata;
   logic          mem_we;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_addr] <= mem_wdata;
      end
      rdata_ff <= mem_array[mem_addr];
   end

   state_type     state_ff, state_in;
   logic [AW-1:0] pc_ff, pc_in;
   logic [SW-1:0] sp_ff, sp_in;
   logic [AW-1:0] fp_ff, fp_in;
   logic          stop_ff, stop_in;
   logic [1:0]    cause_ff, cause_in;
   logic [AW-1:0] clr_ff, clr_in;

   // Transaction operands and working values.
   logic          cmd_ff, cmd_in;
   logic [11:0]   waddr_ff, waddr_in;
   logic [31:0]   wdata_ff, wdata_in;
   logic [31:0]   inval_ff, inval_in;
   logic [4:0]    op_ff, op_in;
   logic [31:0]   va_ff, va_in;
   logic [31:0]   vb_ff, vb_in;

   logic          strobe_ff, strobe_in;
   logic          intk_ff, intk_in;
   logic          outv_ff, outv_in;
   logic          outb_ff, outb_in;
   logic [31:0]   outval_ff, outval_in;

   // Address helpers.
   function automatic logic [AW-1:0] waddr_of(input logic [31:0] v);
      logic [31:0] s;
      s = {{2{v[31]}}, v[31:2]};
      return s[AW-1:0];
   endfunction

   logic [AW-1:0] sp_a, sp1_a;
   logic [SW-1:0] sp_inc1, sp_inc2, sp_dec1;
   assign sp_inc1 = sp_ff + SW'(1);
   assign sp_inc2 = sp_ff + SW'(2);
   assign sp_dec1 = sp_ff - SW'(1);
   assign sp_a    = sp_ff[AW-1:0];
   assign sp1_a   = sp_inc1[AW-1:0];

   logic [31:0] alu_v;
   logic        br_taken;
   logic [4:0]  shamt;
   logic [4:0]  blane;
   logic [7:0]  bsel;
   assign shamt = vb_ff[4:0];
   assign blane = {va_ff[1:0], 3'b000};

   always_comb begin
      unique case (op_ff)
         OP_AND:  alu_v = va_ff & vb_ff;
         OP_OR:   alu_v = va_ff | vb_ff;
         OP_XOR:  alu_v = va_ff ^ vb_ff;
         OP_ADD:  alu_v = va_ff + vb_ff;
         OP_SUB:  alu_v = va_ff - vb_ff;
         OP_SHL:  alu_v = va_ff << shamt;
         OP_SHR:  alu_v = va_ff >> shamt;
         default: alu_v = 32'($signed(va_ff) >>> shamt);
      endcase
      unique case (op_ff)
         OP_BEQ:  br_taken = (va_ff == vb_ff);
         OP_BNE:  br_taken = (va_ff != vb_ff);
         OP_BLT:  br_taken = ($signed(va_ff) < $signed(vb_ff));
         default: br_taken = ($signed(va_ff) >= $signed(vb_ff));
      endcase
      bsel = 8'(rdata_ff >> blane);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         pc_ff     <= '0;
         sp_ff     <= SP_RESET;
         fp_ff     <= '0;
         stop_ff   <= 1'b0;
         cause_ff  <= CAUSE_RUN;
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         sp_ff     <= sp_in;
         fp_ff     <= fp_in;
         stop_ff   <= stop_in;
         cause_ff  <= cause_in;
         clr_ff    <= clr_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      waddr_ff  <= waddr_in;
      wdata_ff  <= wdata_in;
      inval_ff  <= inval_in;
      op_ff     <= op_in;
      va_ff     <= va_in;
      vb_ff     <= vb_in;
      intk_ff   <= intk_in;
      outv_ff   <= outv_in;
      outb_ff   <= outb_in;
      outval_ff <= outval_in;
   end

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      sp_in     = sp_ff;
      fp_in     = fp_ff;
      stop_in   = stop_ff;
      cause_in  = cause_ff;
      clr_in    = clr_ff;
      cmd_in    = cmd_ff;
      waddr_in  = waddr_ff;
      wdata_in  = wdata_ff;
      inval_in  = inval_ff;
      op_in     = op_ff;
      va_in     = va_ff;
      vb_in     = vb_ff;
      intk_in   = intk_ff;
      outv_in   = outv_ff;
      outb_in   = outb_ff;
      outval_in = outval_ff;
      strobe_in = 1'b0;
      mem_addr  = sp_a;
      mem_wdata = '0;
      mem_we    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_addr  = clr_ff;
            mem_we    = 1'b1;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MEM_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd_in    = req_command;
               waddr_in  = req_address;
               wdata_in  = req_write_data;
               inval_in  = req_in_value;
               intk_in   = 1'b0;
               outv_in   = 1'b0;
               outb_in   = 1'b0;
               outval_in = '0;
               state_in  = ST_FETCH;
            end
         end
         ST_FETCH: begin
            // Writes commit here; steps while halted end here; other steps issue the instruction fetch.
            if (cmd_ff == CMD_WRITE) begin
               mem_addr  = AW'(waddr_ff);
               mem_wdata = wdata_ff;
               mem_we    = 1'b1;
               strobe_in = 1'b1;
               state_in  = ST_DONE;
            end else if (stop_ff) begin
               strobe_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               mem_addr = pc_ff;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            op_in    = rdata_ff[4:0];
            state_in = ST_RD1;
            if (rdata_ff > 32'd31 || rdata_ff[4:0] == OP_HLT) begin
               stop_in   = 1'b1;
               cause_in  = (rdata_ff > 32'd31) ? CAUSE_BAD : CAUSE_HLT;
               strobe_in = 1'b1;
               state_in  = ST_DONE;
            end else begin
               // First read: the top of stack, or the inline word after the opcode.
               unique case (rdata_ff[4:0])
                  OP_PSH, OP_BRA: mem_addr = pc_ff + AW'(1);
                  default:        mem_addr = sp_a;
               endcase
            end
         end
         ST_RD1: begin
            // rdata_ff holds the first read.
            state_in = ST_DONE;
            strobe_in = 1'b1;
            unique case (op_ff)
               OP_PSH: begin
                  mem_addr = sp_dec1[AW-1:0]; mem_wdata = rdata_ff; mem_we = 1'b1;
                  sp_in = sp_dec1; pc_in = pc_ff + AW'(2);
               end
               OP_POP: begin sp_in = sp_inc1; pc_in = pc_ff + AW'(1); end
               OP_DUP: begin
                  mem_addr = sp_dec1[AW-1:0]; mem_wdata = rdata_ff; mem_we = 1'b1;
                  sp_in = sp_dec1; pc_in = pc_ff + AW'(1);
               end
               OP_PSHSP: begin
                  mem_addr = sp_dec1[AW-1:0];
                  mem_wdata = 32'({sp_dec1, 2'b00}); mem_we = 1'b1;
                  sp_in = sp_dec1; pc_in = pc_ff + AW'(1);
               end
               OP_POPSP: begin
                  sp_in = SW'({{2{rdata_ff[31]}}, rdata_ff[31:2]} + 32'd1);
                  pc_in = pc_ff + AW'(1);
               end
               OP_PSHFP: begin
                  mem_addr = sp_dec1[AW-1:0];
                  mem_wdata = 32'({fp_ff, 2'b00}); mem_we = 1'b1;
                  sp_in = sp_dec1; pc_in = pc_ff + AW'(1);
               end
               OP_POPFP: begin
                  fp_in = waddr_of(rdata_ff); sp_in = sp_inc1; pc_in = pc_ff + AW'(1);
               end
               OP_BRA: pc_in = waddr_of(rdata_ff);
               OP_JMP: begin pc_in = waddr_of(rdata_ff); sp_in = sp_inc1; end
               OP_IN, OP_INB: begin
                  mem_addr = sp_dec1[AW-1:0]; mem_wdata = inval_ff; mem_we = 1'b1;
                  sp_in = sp_dec1; pc_in = pc_ff + AW'(1); intk_in = 1'b1;
               end
               OP_OUT, OP_OUTB: begin
                  outval_in = rdata_ff; outv_in = 1'b1;
                  outb_in = (op_ff == OP_OUTB);
                  sp_in = sp_inc1; pc_in = pc_ff + AW'(1);
               end
               OP_LDW: begin
                  va_in = rdata_ff; mem_addr = waddr_of(rdata_ff);
                  strobe_in = 1'b0; state_in = ST_EXEC;
               end
               OP_LDB: begin
                  va_in = rdata_ff; mem_addr = rdata_ff[AW+1:2];
                  strobe_in = 1'b0; state_in = ST_EXEC;
               end
               default: begin
                  // Two-operand ops: b is the top, read a (second) next.
                  vb_in = rdata_ff; mem_addr = sp1_a;
                  strobe_in = 1'b0; state_in = ST_RD2;
               end
            endcase
         end
         ST_RD2: begin
            // rdata_ff holds the second stack entry; vb_ff the top.
            va_in    = rdata_ff;
            state_in = ST_RD3;
            unique case (op_ff)
               OP_SWAP: begin
                  mem_addr = sp1_a; mem_wdata = vb_ff; mem_we = 1'b1;
               end
               OP_OVER: begin
                  mem_addr = sp_dec1[AW-1:0]; mem_wdata = rdata_ff; mem_we = 1'b1;
                  sp_in = sp_dec1; pc_in = pc_ff + AW'(1);
                  strobe_in = 1'b1; state_in = ST_DONE;
               end
               OP_BEQ, OP_BNE, OP_BLT, OP_BGE: mem_addr = pc_ff + AW'(1);
               OP_STB: mem_addr = vb_ff[AW+1:2];
               default: mem_addr = sp1_a;
            endcase
         end
         ST_RD3: begin
            // va_ff is the second entry, vb_ff the top.
            strobe_in = 1'b1;
            state_in  = ST_DONE;
            unique case (op_ff)
               OP_SWAP: begin
                  mem_addr = sp_a; mem_wdata = va_ff; mem_we = 1'b1;
                  pc_in = pc_ff + AW'(1);
               end
               OP_BEQ, OP_BNE, OP_BLT, OP_BGE: begin
                  sp_in = sp_inc2;
                  pc_in = br_taken ? waddr_of(rdata_ff) : pc_ff + AW'(2);
               end
               OP_STW: begin
                  mem_addr = waddr_of(vb_ff); mem_wdata = va_ff; mem_we = 1'b1;
                  sp_in = sp_inc2; pc_in = pc_ff + AW'(1);
               end
               OP_STB: begin
                  mem_addr = vb_ff[AW+1:2];
                  mem_wdata = (rdata_ff & ~(BYTE_MASK << {vb_ff[1:0], 3'b000}))
                            | ((va_ff & BYTE_MASK) << {vb_ff[1:0], 3'b000});
                  mem_we = 1'b1;
                  sp_in = sp_inc2; pc_in = pc_ff + AW'(1);
               end
               default: begin
                  mem_addr = sp1_a; mem_wdata = alu_v; mem_we = 1'b1;
                  sp_in = sp_inc1; pc_in = pc_ff + AW'(1);
               end
            endcase
         end
         ST_EXEC: begin
            // Loads: rdata_ff holds the addressed word; result replaces the top.
            mem_addr  = sp_a;
            mem_we    = 1'b1;
            mem_wdata = (op_ff == OP_LDB) ? 32'($signed(bsel)) : rdata_ff;
            pc_in     = pc_ff + AW'(1);
            strobe_in = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_halted      = stop_ff;
   assign rsp_halt_cause  = cause_ff;
   assign rsp_in_taken    = intk_ff;
   assign rsp_out_valid   = outv_ff;
   assign rsp_out_is_byte = outb_ff;
   assign rsp_out_value   = outval_ff;
   assign rsp_pc_now      = 12'(pc_ff);
   assign rsp_sp_now      = 13'(sp_ff);
   assign rsp_fp_now      = 12'(fp_ff);

   // A result strobe is only ever shown during the done state.
   a_strobe_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == ST_DONE)
      else $error("result strobe outside transaction end");
   // A halted core never moves its program counter.
   a_halt_pc: assert property (@(posedge clock) disable iff (reset)
      $past(stop_ff) && stop_ff |-> $stable(pc_ff))
      else $error("program counter moved while halted");
   // Output and input flags never appear together.
   a_io_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_in_taken && rsp_out_valid))
      else $error("input and output in one step");

endmodule
